// ----- design/sem_pkg.sv -----
// shared types and constants of the sobel edge magnitude block
`default_nettype none
package sem_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  localparam int RegW   = 11;
  localparam int CfgIdxW = 2;
  localparam int PixW   = 24;
  localparam int GradW  = 11;
  localparam int SqW    = 20;
  localparam int SumW   = 21;

  localparam logic [RegW-1:0] WidthReset  = RegW'(640);
  localparam logic [RegW-1:0] HeightReset = RegW'(480);

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  localparam logic [7:0]      MagMax  = 8'd255;
  localparam logic [SumW-1:0] SqLimit = SumW'(65280);

  // controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       update;
    logic       grad;
    logic       square;
    logic       sum;
    logic       iter;
    logic       fin;
    logic       load;
    logic [1:0] chan;
    logic [2:0] step;
  } sem_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic res;
    logic out_free;
  } sem_stat_t;

endpackage
`default_nettype wire

// ----- design/sobel_edge_magnitude_rgb.sv -----
// top level of the rgb sobel edge magnitude block
//
//  channel  handshake                  payload
//  in       in_valid_i / in_ready_o    action_i, in_red_i, in_green_i, in_blue_i
//  out      out_valid_o / out_ready_i  out_red_o, out_green_o, out_blue_o, frame_end_o
//  cfg      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// a request that gives no result passes through accept with line buffer read, then update.
// a request that gives a result adds gradient, then square, sum, root steps and finish
// per channel in turn, then load; the shared square root unit resolves one bit per cycle.
// reset clears the counters and the window; line buffers are not cleared.
// a finished result waits in the output register while the next request is taken.
`default_nettype none
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = sem_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = sem_pkg::MaxHeightDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sem_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sem_pkg::RegW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        action_i,
  input  wire logic [7:0]                  in_red_i,
  input  wire logic [7:0]                  in_green_i,
  input  wire logic [7:0]                  in_blue_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       out_red_o,
  output logic [7:0]                       out_green_o,
  output logic [7:0]                       out_blue_o,
  output logic                             frame_end_o
);
  import sem_pkg::*;

  sem_cmd_t  cmd;
  sem_stat_t stat;

  // controller
  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .frame_end_o (frame_end_o)
  );

endmodule
`default_nettype wire

// ----- design/sem_ctrl.sv -----
// controller state machine of the sobel edge magnitude block
`default_nettype none
module sem_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sem_pkg::sem_stat_t stat_i,
  output sem_pkg::sem_cmd_t       cmd_o
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_GRAD, ST_SQ, ST_SUM, ST_ITER, ST_FIN, ST_LOAD
  } state_e;

  state_e     state_q;
  logic [1:0] chan_q;
  logic [2:0] step_q;

  assign in_ready_o = (state_q == ST_IDLE);

  // command decode
  always_comb begin
    cmd_o        = '0;
    cmd_o.chan   = chan_q;
    cmd_o.step   = step_q;
    cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.update = (state_q == ST_UPD);
    cmd_o.grad   = (state_q == ST_GRAD);
    cmd_o.square = (state_q == ST_SQ);
    cmd_o.sum    = (state_q == ST_SUM);
    cmd_o.iter   = (state_q == ST_ITER);
    cmd_o.fin    = (state_q == ST_FIN);
    cmd_o.load   = (state_q == ST_LOAD) && stat_i.out_free;
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= '0;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_UPD;
        end
        ST_UPD: begin
          state_q <= stat_i.res ? ST_GRAD : ST_IDLE;
        end
        ST_GRAD: begin
          chan_q  <= '0;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          step_q  <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (chan_q == 2'd2) begin
            state_q <= ST_LOAD;
          end else begin
            chan_q  <= chan_q + 2'd1;
            state_q <= ST_SQ;
          end
        end
        ST_LOAD: begin
          if (stat_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/sem_datapath.sv -----
// line buffers, window, counters and magnitude unit of the sobel block
`default_nettype none
module sem_datapath #(
  parameter int MAX_WIDTH  = sem_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = sem_pkg::MaxHeightDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sem_pkg::sem_cmd_t        cmd_i,
  output sem_pkg::sem_stat_t            stat_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [sem_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sem_pkg::RegW-1:0] cfg_wdata_i,
  input  wire logic                     action_i,
  input  wire logic [7:0]               in_red_i,
  input  wire logic [7:0]               in_green_i,
  input  wire logic [7:0]               in_blue_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic                          frame_end_o
);
  import sem_pkg::*;

  localparam int WDW  = $clog2(MAX_WIDTH + 1);
  localparam int HDW  = $clog2(MAX_HEIGHT + 1);
  localparam int ADW  = $clog2(MAX_WIDTH);
  localparam int RWW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [RegW-1:0] width_q, height_q;
  logic [WDW-1:0]  w_eff;
  logic [HDW-1:0]  h_eff;
  logic [CNTW-1:0] total;
  logic [31:0]     wraw, hraw;

  logic [CNTW-1:0] in_count_q, out_index_q;
  logic [ADW-1:0]  in_col_q, out_col_q;
  logic [RWW-1:0]  out_row_q;
  logic            go_q;
  logic [PixW-1:0] data_q;
  logic [ADW-1:0]  addr_q;
  logic [PixW-1:0] up_rd_q, mid_rd_q;
  logic [PixW-1:0] upper_mem [MAX_WIDTH];
  logic [PixW-1:0] middle_mem [MAX_WIDTH];
  logic [PixW-1:0] win_q [3][3];

  logic            restart, go_now, res_now, in_wrap, out_wrap;
  logic [ADW-1:0]  rd_addr;
  logic            rm0_q, rm2_q, cm0_q, cm2_q, fe_q;

  logic signed [GradW-1:0] gx_q [3];
  logic signed [GradW-1:0] gy_q [3];
  logic signed [GradW-1:0] gx_d [3];
  logic signed [GradW-1:0] gy_d [3];
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic [SumW-1:0]         s_q;
  logic [7:0]              r_q;
  logic [7:0]              mag_q [3];
  logic                    out_valid_q;

  // effective frame size
  always_comb begin
    wraw = 32'(width_q);
    hraw = 32'(height_q);
    if (wraw == 32'd0)                  w_eff = WDW'(1);
    else if (wraw > 32'(MAX_WIDTH))     w_eff = WDW'(MAX_WIDTH);
    else                                w_eff = WDW'(wraw);
    if (hraw == 32'd0)                  h_eff = HDW'(1);
    else if (hraw > 32'(MAX_HEIGHT))    h_eff = HDW'(MAX_HEIGHT);
    else                                h_eff = HDW'(hraw);
    total = CNTW'(32'(w_eff) * 32'(h_eff));
  end

  // request classification at accept
  assign restart = !action_i && (in_count_q >= total);
  assign go_now  = !action_i || ((in_count_q >= total) && (out_index_q < total));
  assign rd_addr = restart ? '0 : in_col_q;
  assign res_now = go_q && (32'(in_count_q) >= 32'(w_eff) + 32'd1) && (out_index_q < total);
  assign in_wrap  = (32'(in_col_q) + 32'd1 >= 32'(w_eff));
  assign out_wrap = (32'(out_col_q) + 32'd1 >= 32'(w_eff));

  assign stat_o.res      = res_now;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFrameWidth)  width_q  <= cfg_wdata_i;
      if (cfg_idx_i == CfgFrameHeight) height_q <= cfg_wdata_i;
    end
  end

  // frame position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= '0;
      out_index_q <= '0;
      in_col_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      go_q        <= 1'b0;
    end else if (cfg_we_i &&
                 (cfg_idx_i == CfgFrameWidth || cfg_idx_i == CfgFrameHeight)) begin
      in_count_q  <= '0;
      out_index_q <= '0;
      in_col_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
    end else if (cmd_i.accept) begin
      go_q <= go_now;
      if (restart) begin
        in_count_q  <= '0;
        out_index_q <= '0;
        in_col_q    <= '0;
        out_col_q   <= '0;
        out_row_q   <= '0;
      end
    end else if (cmd_i.update && go_q) begin
      in_count_q <= in_count_q + CNTW'(1);
      in_col_q   <= in_wrap ? '0 : in_col_q + ADW'(1);
      if (res_now) begin
        out_index_q <= out_index_q + CNTW'(1);
        if (out_wrap) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RWW'(1);
        end else begin
          out_col_q <= out_col_q + ADW'(1);
        end
      end
    end
  end

  // captured request and edge masks
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q <= action_i ? '0 : {in_blue_i, in_green_i, in_red_i};
      addr_q <= rd_addr;
    end
    if (cmd_i.update && res_now) begin
      rm0_q <= (out_row_q != '0);
      rm2_q <= (32'(out_row_q) + 32'd1 < 32'(h_eff));
      cm0_q <= (out_col_q != '0);
      cm2_q <= !out_wrap;
      fe_q  <= (32'(out_index_q) + 32'd1 == 32'(total));
    end
  end

  // line buffer memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) up_rd_q <= upper_mem[rd_addr];
    if (cmd_i.update && go_q) upper_mem[addr_q] <= mid_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) mid_rd_q <= middle_mem[rd_addr];
    if (cmd_i.update && go_q) middle_mem[addr_q] <= data_q;
  end

  // 3x3 window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
      end
    end else if (cmd_i.update && go_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_rd_q;
      win_q[1][2] <= mid_rd_q;
      win_q[2][2] <= data_q;
    end
  end

  // masked sobel sums per channel
  always_comb begin
    logic signed [GradW-1:0] p [3][3];
    logic                    rm [3];
    logic                    cm [3];
    rm[0] = rm0_q; rm[1] = 1'b1; rm[2] = rm2_q;
    cm[0] = cm0_q; cm[1] = 1'b1; cm[2] = cm2_q;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p[r][c] = (rm[r] && cm[c]) ? GradW'(win_q[r][c][ch*8 +: 8]) : '0;
        end
      end
      gx_d[ch] = (p[0][2] + (p[1][2] <<< 1) + p[2][2]) - (p[0][0] + (p[1][0] <<< 1) + p[2][0]);
      gy_d[ch] = (p[2][0] + (p[2][1] <<< 1) + p[2][2]) - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
    end
  end

  // gradients, squares and bitwise square root
  always_ff @(posedge clk_i) begin
    logic signed [2*GradW-1:0] px, py;
    logic [7:0]                t;
    logic [15:0]               tt;
    logic [15:0]               rr;
    logic [SumW-1:0]           rem;
    px  = gx_q[cmd_i.chan] * gx_q[cmd_i.chan];
    py  = gy_q[cmd_i.chan] * gy_q[cmd_i.chan];
    t   = r_q | (8'h80 >> cmd_i.step);
    tt  = t * t;
    rr  = r_q * r_q;
    rem = s_q - SumW'(rr);
    if (cmd_i.grad) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
    end
    if (cmd_i.square) begin
      sqx_q <= px[SqW-1:0];
      sqy_q <= py[SqW-1:0];
    end
    if (cmd_i.sum) begin
      s_q <= SumW'(sqx_q) + SumW'(sqy_q);
      r_q <= '0;
    end
    if (cmd_i.iter && (SumW'(tt) <= s_q)) r_q <= t;
    if (cmd_i.fin) begin
      if (s_q > SqLimit)          mag_q[cmd_i.chan] <= MagMax;
      else if (rem > SumW'(r_q))  mag_q[cmd_i.chan] <= r_q + 8'd1;
      else                        mag_q[cmd_i.chan] <= r_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_red_o   <= mag_q[0];
      out_green_o <= mag_q[1];
      out_blue_o  <= mag_q[2];
      frame_end_o <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
